### rtl/tdt_pkg.sv
// ----------------------------------------------------------------------------
// tdt_pkg
// Shared sizes, codes and types of the table-driven DFA tokenizer.
// ----------------------------------------------------------------------------
package tdt_pkg;

   localparam int MAX_STATES  = 64;
   localparam int MAX_SYMBOLS = 64;

   localparam int STATE_W = $clog2(MAX_STATES);
   localparam int COL_W   = $clog2(MAX_SYMBOLS);
   localparam int ENTRY_W = STATE_W + 1;
   localparam int SYM_W   = 7;
   localparam int CODE_W  = 16;
   localparam int MODE_W  = 3;
   localparam int KIND_W  = 2;
   localparam int BYTE_W  = 8;
   localparam int INDEX_W = 6;

   localparam logic [MODE_W-1:0] MODE_SCAN  = 3'd0;
   localparam logic [MODE_W-1:0] MODE_END   = 3'd1;
   localparam logic [MODE_W-1:0] MODE_SYM   = 3'd2;
   localparam logic [MODE_W-1:0] MODE_TRANS = 3'd3;
   localparam logic [MODE_W-1:0] MODE_CODE  = 3'd4;

   localparam logic [KIND_W-1:0] KIND_TOKEN   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ERROR   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_SUCCESS = 2'd2;

   // one transition entry: {no_transition, next_state}
   typedef logic [ENTRY_W-1:0] entry_type;
   typedef entry_type [MAX_STATES-1:0] column_type;

   // transaction leaving the lookup front end
   typedef struct packed {
      logic                       valid;
      logic [MODE_W-1:0]          mode;
      logic [INDEX_W-1:0]         row_index;
      logic signed [CODE_W-1:0]   entry_value;
      logic                       blank;
      logic                       mapped;
   } stage_type;

endpackage

### rtl/tdt_req_if.sv
// ----------------------------------------------------------------------------
// tdt_req_if
// Request channel: table loads, text bytes and end of text.
// ----------------------------------------------------------------------------
interface tdt_req_if;

   logic                                  valid;
   logic                                  ready;
   logic [tdt_pkg::MODE_W-1:0]            mode;
   logic [tdt_pkg::BYTE_W-1:0]            char_byte;
   logic [tdt_pkg::INDEX_W-1:0]           row_index;
   logic [tdt_pkg::INDEX_W-1:0]           column_index;
   logic signed [tdt_pkg::CODE_W-1:0]     entry_value;

   modport source (
      output valid, mode, char_byte, row_index, column_index, entry_value,
      input  ready
   );

   modport sink (
      input  valid, mode, char_byte, row_index, column_index, entry_value,
      output ready
   );

endinterface

### rtl/tdt_rsp_if.sv
// ----------------------------------------------------------------------------
// tdt_rsp_if
// Response channel: token, error and accept results.
// ----------------------------------------------------------------------------
interface tdt_rsp_if;

   logic                                  valid;
   logic                                  ready;
   logic [tdt_pkg::KIND_W-1:0]            result_kind;
   logic signed [tdt_pkg::CODE_W-1:0]     token_code;
   logic                                  last;

   modport source (
      output valid, result_kind, token_code, last,
      input  ready
   );

   modport sink (
      input  valid, result_kind, token_code, last,
      output ready
   );

endinterface

### rtl/tdt_front.sv
// ----------------------------------------------------------------------------
// tdt_front
// Symbol map lookup and transition column fetch, two registered stages.
// Loads of the symbol map and transition table are written on acceptance.
// ----------------------------------------------------------------------------
module tdt_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   tdt_req_if.sink              req_chan,
   output tdt_pkg::stage_type   stage,
   output tdt_pkg::column_type  column
);

   logic [tdt_pkg::SYM_W-1:0]        sym_mem [256];
   logic [255:0]                     sym_valid_ff;
   tdt_pkg::column_type              trans_mem [tdt_pkg::MAX_SYMBOLS];

   logic                             accept;
   logic                             req_blank;
   logic                             trans_none;

   logic                             s1_valid_ff;
   logic [tdt_pkg::MODE_W-1:0]       s1_mode_ff;
   logic [tdt_pkg::INDEX_W-1:0]      s1_row_ff;
   logic signed [tdt_pkg::CODE_W-1:0] s1_value_ff;
   logic                             s1_blank_ff;
   logic [tdt_pkg::SYM_W-1:0]        sym_rd_ff;
   logic                             sym_hit_ff;

   logic [tdt_pkg::SYM_W-1:0]        sym_code;
   logic                             s1_mapped;
   logic [tdt_pkg::COL_W-1:0]        s1_col;

   tdt_pkg::stage_type               s2_ff;
   tdt_pkg::stage_type               s2_in;
   tdt_pkg::column_type              col_rd_ff;

   assign accept = req_chan.valid && adv;

   assign req_blank = (req_chan.char_byte == 8'h20) ||
                      ((req_chan.char_byte >= 8'h09) && (req_chan.char_byte <= 8'h0d));

   assign trans_none = (req_chan.entry_value < 0) ||
                       (int'(req_chan.entry_value) >= tdt_pkg::MAX_STATES);

   // symbol map: valid bits cleared by reset, data unreset
   always_ff @(posedge clock) begin
      if (reset) begin
         sym_valid_ff <= '0;
      end else if (accept && (req_chan.mode == tdt_pkg::MODE_SYM)) begin
         sym_valid_ff[req_chan.char_byte] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && (req_chan.mode == tdt_pkg::MODE_SYM)) begin
         sym_mem[req_chan.char_byte] <= req_chan.entry_value[tdt_pkg::SYM_W-1:0];
      end
      if (adv) begin
         sym_rd_ff  <= sym_mem[req_chan.char_byte];
         sym_hit_ff <= sym_valid_ff[req_chan.char_byte];
      end
   end

   // transition table: one word per column, one lane per state
   always_ff @(posedge clock) begin
      if (accept && (req_chan.mode == tdt_pkg::MODE_TRANS) &&
          (int'(req_chan.row_index) < tdt_pkg::MAX_STATES) &&
          (int'(req_chan.column_index) < tdt_pkg::MAX_SYMBOLS)) begin
         trans_mem[req_chan.column_index[tdt_pkg::COL_W-1:0]]
                  [req_chan.row_index[tdt_pkg::STATE_W-1:0]] <=
            {trans_none, req_chan.entry_value[tdt_pkg::STATE_W-1:0]};
      end
      if (adv) begin
         col_rd_ff <= trans_mem[s1_col];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_mode_ff  <= req_chan.mode;
         s1_row_ff   <= req_chan.row_index;
         s1_value_ff <= req_chan.entry_value;
         s1_blank_ff <= req_blank;
      end
   end

   assign sym_code  = sym_hit_ff ? sym_rd_ff : '0;
   assign s1_mapped = (sym_code != '0) && (int'(sym_code) <= tdt_pkg::MAX_SYMBOLS);
   assign s1_col    = tdt_pkg::COL_W'(sym_code - 1'b1);

   always_comb begin
      s2_in.valid       = s1_valid_ff;
      s2_in.mode        = s1_mode_ff;
      s2_in.row_index   = s1_row_ff;
      s2_in.entry_value = s1_value_ff;
      s2_in.blank       = s1_blank_ff;
      s2_in.mapped      = s1_mapped;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ff.valid <= 1'b0;
      end else if (adv) begin
         s2_ff.valid <= s2_in.valid;
      end
      if (adv) begin
         s2_ff.mode        <= s2_in.mode;
         s2_ff.row_index   <= s2_in.row_index;
         s2_ff.entry_value <= s2_in.entry_value;
         s2_ff.blank       <= s2_in.blank;
         s2_ff.mapped      <= s2_in.mapped;
      end
   end

   assign stage  = s2_ff;
   assign column = col_rd_ff;

endmodule

### rtl/table_driven_dfa_tokenizer_top.sv
// ----------------------------------------------------------------------------
// table_driven_dfa_tokenizer_top
// Table-driven DFA tokenizer: DFA step, token code lookup, result register.
//
//   channel   dir  handshake            payload
//   req_chan  in   valid/ready          mode, char_byte, row_index,
//                                       column_index, entry_value
//   rsp_chan  out  valid/ready          result_kind, token_code, last
//
// One transaction accepted per cycle unless the pipeline stalls; the first result
// is valid once it has passed the symbol map read, the transition column read
// and the result register load (the token code is read together with that load).
// End of text inside a token gives two results, the token and then success.
// The pipeline stalls only when a transaction that yields results reaches
// the DFA step while the result register cannot empty.
// Reset clears the 256 symbol map valid bits at once; no clearing pass.
// ----------------------------------------------------------------------------
module table_driven_dfa_tokenizer_top (
   input  logic          clock,
   input  logic          reset,
   tdt_req_if.sink       req_chan,
   tdt_rsp_if.source     rsp_chan
);

   tdt_pkg::stage_type                 stage;
   tdt_pkg::column_type                column;
   tdt_pkg::entry_type                 entry;

   logic signed [tdt_pkg::CODE_W-1:0]  code_mem [tdt_pkg::MAX_STATES];
   logic signed [tdt_pkg::CODE_W-1:0]  code_rd_ff;

   logic [tdt_pkg::STATE_W-1:0]        state_ff, state_in;
   logic                               inside_ff, inside_in;
   logic                               error_ff, error_in;

   logic                               d_valid_ff;
   logic                               d_two_ff;
   logic [tdt_pkg::KIND_W-1:0]         d_kind_ff;
   logic                               d_use_code_ff;

   logic                               emits;
   logic                               emit_two;
   logic [tdt_pkg::KIND_W-1:0]         emit_kind;
   logic                               emit_code;
   logic                               d_busy;
   logic                               adv;
   logic                               step;
   logic                               pop;

   tdt_front u_front (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .req_chan (req_chan),
      .stage    (stage),
      .column   (column)
   );

   assign entry = column[state_ff];

   always_comb begin
      state_in  = state_ff;
      inside_in = inside_ff;
      error_in  = error_ff;
      emits     = 1'b0;
      emit_two  = 1'b0;
      emit_kind = tdt_pkg::KIND_TOKEN;
      emit_code = 1'b0;
      unique case (stage.mode)
         tdt_pkg::MODE_SCAN: begin
            if (!error_ff) begin
               if (stage.blank) begin
                  if (inside_ff) begin
                     emits     = 1'b1;
                     emit_code = 1'b1;
                     state_in  = '0;
                     inside_in = 1'b0;
                  end
               end else if (!stage.mapped || entry[tdt_pkg::STATE_W]) begin
                  emits     = 1'b1;
                  emit_kind = tdt_pkg::KIND_ERROR;
                  error_in  = 1'b1;
                  state_in  = '0;
                  inside_in = 1'b0;
               end else begin
                  state_in  = entry[tdt_pkg::STATE_W-1:0];
                  inside_in = 1'b1;
               end
            end
         end
         tdt_pkg::MODE_END: begin
            if (!error_ff) begin
               emits = 1'b1;
               if (inside_ff) begin
                  emit_two  = 1'b1;
                  emit_code = 1'b1;
               end else begin
                  emit_kind = tdt_pkg::KIND_SUCCESS;
               end
            end
            state_in  = '0;
            inside_in = 1'b0;
            error_in  = 1'b0;
         end
         default: begin
         end
      endcase
   end

   assign pop    = d_valid_ff && rsp_chan.ready;
   assign d_busy = d_valid_ff && !(rsp_chan.ready && !d_two_ff);
   assign adv    = !(stage.valid && emits && d_busy);
   assign step   = adv && stage.valid;

   assign req_chan.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= '0;
         inside_ff <= 1'b0;
         error_ff  <= 1'b0;
      end else if (step) begin
         state_ff  <= state_in;
         inside_ff <= inside_in;
         error_ff  <= error_in;
      end
   end

   // token code table, written in order with its reads
   always_ff @(posedge clock) begin
      if (step && (stage.mode == tdt_pkg::MODE_CODE) &&
          (int'(stage.row_index) < tdt_pkg::MAX_STATES)) begin
         code_mem[stage.row_index[tdt_pkg::STATE_W-1:0]] <= stage.entry_value;
      end
      if (step && emits) begin
         code_rd_ff <= code_mem[state_ff];
      end
   end

   // result register, holds up to two results of one transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
         d_two_ff   <= 1'b0;
      end else if (step && emits) begin
         d_valid_ff <= 1'b1;
         d_two_ff   <= emit_two;
      end else if (pop) begin
         d_valid_ff <= d_two_ff;
         d_two_ff   <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step && emits) begin
         d_kind_ff     <= emit_kind;
         d_use_code_ff <= emit_code;
      end else if (pop && d_two_ff) begin
         d_kind_ff     <= tdt_pkg::KIND_SUCCESS;
         d_use_code_ff <= 1'b0;
      end
   end

   assign rsp_chan.valid       = d_valid_ff;
   assign rsp_chan.result_kind = d_kind_ff;
   assign rsp_chan.token_code  = d_use_code_ff ? code_rd_ff : '0;
   assign rsp_chan.last        = !d_two_ff;

   a_stall_holds_state: assert property (@(posedge clock) disable iff (reset)
      (stage.valid && emits && d_busy) |=> ($stable(state_ff) && $stable(error_ff)))
      else $error("DFA state changed during a stall");

   a_stall_blocks_req: assert property (@(posedge clock) disable iff (reset)
      (stage.valid && emits && d_busy) |-> !req_chan.ready)
      else $error("request taken while result register is full");

   a_second_is_success: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.ready && !rsp_chan.last) |=>
      (rsp_chan.valid && (rsp_chan.result_kind == tdt_pkg::KIND_SUCCESS)))
      else $error("first of two results not followed by success");

   a_error_resets_dfa: assert property (@(posedge clock) disable iff (reset)
      error_ff |-> (!inside_ff && (state_ff == '0)))
      else $error("DFA not at start state after error");

endmodule

### verif/tdt_lex_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tdt_lex_checker
// Watches the request and response channels of the DFA tokenizer, keeps its
// own copy of the symbol map, transition table, token codes and scan state,
// predicts the results of every accepted request transaction and compares
// each accepted response transaction with the oldest prediction.
// ----------------------------------------------------------------------------
module tdt_lex_checker
   import tdt_pkg::*;
(
   input  logic   clock,
   input  logic   reset,
   tdt_req_if     req_mon,
   tdt_rsp_if     rsp_mon,
   output int     mismatches,
   output int     results_pending
);

   localparam int                NO_NEXT      = -1;
   localparam int                REPORT_LIMIT = 10;
   localparam logic [BYTE_W-1:0] CHR_TAB      = 8'h09;
   localparam logic [BYTE_W-1:0] CHR_CR       = 8'h0D;
   localparam logic [BYTE_W-1:0] CHR_SPACE    = 8'h20;

   typedef struct packed {
      logic [KIND_W-1:0]        kind;
      logic signed [CODE_W-1:0] code;
      logic                     last;
   } lex_result_type;

   lex_result_type           lex_results [$];
   logic [SYM_W-1:0]         char_column [256];
   int                       next_state  [MAX_STATES*MAX_SYMBOLS];
   logic signed [CODE_W-1:0] token_of_state [MAX_STATES];
   int                       dfa_state;
   bit                       in_token;
   bit                       error_seen;

   function automatic bit is_blank(logic [BYTE_W-1:0] b);
      return b == CHR_SPACE || (b >= CHR_TAB && b <= CHR_CR);
   endfunction

   function automatic void emit(logic [KIND_W-1:0] kind, logic signed [CODE_W-1:0] code);
      lex_results.push_back('{kind, code, 1'b0});
   endfunction

   task automatic lex_item(
      input logic [MODE_W-1:0]        mode,
      input logic [BYTE_W-1:0]        ch,
      input logic [INDEX_W-1:0]       row,
      input logic [INDEX_W-1:0]       col,
      input logic signed [CODE_W-1:0] val
   );
      int               n_before;
      logic [SYM_W-1:0] sym;
      int               nx;
      lex_result_type   tail;
      n_before = lex_results.size();
      case (mode)
         MODE_SCAN: begin
            if (!error_seen) begin
               if (is_blank(ch)) begin
                  if (in_token) begin
                     emit(KIND_TOKEN, token_of_state[dfa_state]);
                     dfa_state = 0;
                     in_token  = 1'b0;
                  end
               end else begin
                  sym = char_column[ch];
                  nx  = NO_NEXT;
                  if (sym != 0 && sym <= MAX_SYMBOLS)
                     nx = next_state[dfa_state*MAX_SYMBOLS + int'(sym) - 1];
                  if (nx < 0) begin
                     emit(KIND_ERROR, '0);
                     error_seen = 1'b1;
                     dfa_state  = 0;
                     in_token   = 1'b0;
                  end else begin
                     dfa_state = nx;
                     in_token  = 1'b1;
                  end
               end
            end
         end
         MODE_END: begin
            if (!error_seen) begin
               if (in_token)
                  emit(KIND_TOKEN, token_of_state[dfa_state]);
               emit(KIND_SUCCESS, '0);
            end
            dfa_state  = 0;
            in_token   = 1'b0;
            error_seen = 1'b0;
         end
         MODE_SYM: char_column[ch] = val[SYM_W-1:0];
         MODE_TRANS: begin
            if (row < MAX_STATES && col < MAX_SYMBOLS)
               next_state[int'(row)*MAX_SYMBOLS + int'(col)] =
                  (val < 0 || val >= MAX_STATES) ? NO_NEXT : int'(val);
         end
         MODE_CODE: begin
            if (row < MAX_STATES)
               token_of_state[row] = val;
         end
         default: ;
      endcase
      if (lex_results.size() > n_before) begin
         tail      = lex_results.pop_back();
         tail.last = 1'b1;
         lex_results.push_back(tail);
      end
   endtask

   always @(posedge clock) begin
      lex_result_type want;
      if (reset) begin
         foreach (char_column[i]) char_column[i] = '0;
         foreach (next_state[i]) next_state[i] = 0;
         foreach (token_of_state[i]) token_of_state[i] = '0;
         lex_results.delete();
         dfa_state       = 0;
         in_token        = 1'b0;
         error_seen      = 1'b0;
         mismatches      = 0;
         results_pending = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (lex_results.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("%0t: unexpected result kind %0d code %0d last %0b", $realtime,
                           rsp_mon.result_kind, rsp_mon.token_code, rsp_mon.last);
            end else begin
               want = lex_results.pop_front();
               if (rsp_mon.result_kind !== want.kind || rsp_mon.token_code !== want.code ||
                   rsp_mon.last !== want.last) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT)
                     $display({"%0t: result mismatch, expected kind %0d code %0d last %0b,",
                               " got kind %0d code %0d last %0b"}, $realtime,
                              want.kind, want.code, want.last, rsp_mon.result_kind,
                              rsp_mon.token_code, rsp_mon.last);
               end
            end
         end
         if (req_mon.valid && req_mon.ready)
            lex_item(req_mon.mode, req_mon.char_byte, req_mon.row_index,
                     req_mon.column_index, req_mon.entry_value);
         results_pending = lex_results.size();
      end
   end

endmodule

### verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the DFA tokenizer. A short directed text covers
// table limits and the error and end-of-text cases; random tables and texts
// follow under four flow-control phases, with one long response hold-off.
// Scan bytes are chosen so that no unwritten table entry is ever read.
// ----------------------------------------------------------------------------
module tb_top;
   import tdt_pkg::*;

   localparam int HALF_PERIOD    = 5;
   localparam int RESET_CYCLES   = 6;
   localparam int ITEM_TARGET    = 950;
   localparam int PHASES         = 4;
   localparam int HOLD_AT        = 150;
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 12;
   localparam int UNWRITTEN      = -2;
   localparam int NO_NEXT        = -1;

   localparam logic signed [CODE_W-1:0] NONE_VALUE        = -16'sd1;
   localparam logic [MODE_W-1:0]        MODE_UNUSED_FIRST = 3'd5;
   localparam logic [MODE_W-1:0]        MODE_UNUSED_LAST  = 3'd7;
   localparam logic [BYTE_W-1:0]        CHR_TAB           = 8'h09;
   localparam logic [BYTE_W-1:0]        CHR_CR            = 8'h0D;
   localparam logic [BYTE_W-1:0]        CHR_SPACE         = 8'h20;
   localparam logic [BYTE_W-1:0]        CHR_A             = 8'h61;
   localparam logic [BYTE_W-1:0]        CHR_B             = 8'h62;

   logic clock = 1'b0;
   logic reset = 1'b1;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   bit hold_req       = 1'b0;
   int items_sent     = 0;
   int quiet_cycles   = 0;
   int mismatches;
   int results_pending;

   // lookup shadow used only to keep scan bytes away from unwritten entries
   logic [SYM_W-1:0] shadow_column   [256];
   int               shadow_next     [MAX_STATES][MAX_SYMBOLS];
   bit               shadow_has_code [MAX_STATES];
   int               shadow_state;
   bit               shadow_in_token;
   bit               shadow_error;

   int               dfa_states [$];
   logic [BYTE_W-1:0] dfa_bytes [$];

   tdt_req_if req_chan ();
   tdt_rsp_if rsp_chan ();

   table_driven_dfa_tokenizer_top u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   tdt_lex_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_chan),
      .rsp_mon         (rsp_chan),
      .mismatches      (mismatches),
      .results_pending (results_pending)
   );

   always #HALF_PERIOD clock = ~clock;

   function automatic bit is_blank(logic [BYTE_W-1:0] b);
      return b == CHR_SPACE || (b >= CHR_TAB && b <= CHR_CR);
   endfunction

   function automatic logic [BYTE_W-1:0] word_byte();
      logic [BYTE_W-1:0] b;
      do b = 8'($urandom); while (is_blank(b));
      return b;
   endfunction

   function automatic logic signed [CODE_W-1:0] next_state_value();
      logic signed [CODE_W-1:0] v;
      if ($urandom_range(99) < 92) begin
         v = 16'(dfa_states[$urandom_range(dfa_states.size() - 1)]);
      end else begin
         v = 16'($urandom);
         if (v >= 0 && v < MAX_STATES)
            v = NONE_VALUE;
      end
      return v;
   endfunction

   function automatic bit scan_is_safe(logic [BYTE_W-1:0] ch);
      logic [SYM_W-1:0] sym;
      int               nx;
      if (shadow_error)
         return 1'b1;
      if (is_blank(ch))
         return !shadow_in_token || shadow_has_code[shadow_state];
      sym = shadow_column[ch];
      if (sym == 0 || sym > MAX_SYMBOLS)
         return 1'b1;
      nx = shadow_next[shadow_state][int'(sym) - 1];
      if (nx == UNWRITTEN)
         return 1'b0;
      return nx < 0 || shadow_has_code[nx];
   endfunction

   function automatic void follow_item(
      logic [MODE_W-1:0]        mode,
      logic [BYTE_W-1:0]        ch,
      logic [INDEX_W-1:0]       row,
      logic [INDEX_W-1:0]       col,
      logic signed [CODE_W-1:0] val
   );
      logic [SYM_W-1:0] sym;
      int               nx;
      case (mode)
         MODE_SCAN: begin
            if (!shadow_error) begin
               if (is_blank(ch)) begin
                  shadow_state    = 0;
                  shadow_in_token = 1'b0;
               end else begin
                  sym = shadow_column[ch];
                  nx  = NO_NEXT;
                  if (sym != 0 && sym <= MAX_SYMBOLS)
                     nx = shadow_next[shadow_state][int'(sym) - 1];
                  if (nx < 0) begin
                     shadow_error    = 1'b1;
                     shadow_state    = 0;
                     shadow_in_token = 1'b0;
                  end else begin
                     shadow_state    = nx;
                     shadow_in_token = 1'b1;
                  end
               end
            end
         end
         MODE_END: begin
            shadow_state    = 0;
            shadow_in_token = 1'b0;
            shadow_error    = 1'b0;
         end
         MODE_SYM: shadow_column[ch] = val[SYM_W-1:0];
         MODE_TRANS: shadow_next[row][col] = (val < 0 || val >= MAX_STATES) ? NO_NEXT : int'(val);
         MODE_CODE: shadow_has_code[row] = 1'b1;
         default: ;
      endcase
   endfunction

   task automatic send_item(
      input logic [MODE_W-1:0]        mode,
      input logic [BYTE_W-1:0]        ch,
      input logic [INDEX_W-1:0]       row,
      input logic [INDEX_W-1:0]       col,
      input logic signed [CODE_W-1:0] val
   );
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.mode         <= mode;
      req_chan.char_byte    <= ch;
      req_chan.row_index    <= row;
      req_chan.column_index <= col;
      req_chan.entry_value  <= val;
      do @(posedge clock); while (!req_chan.ready);
      follow_item(mode, ch, row, col, val);
      if (mode <= MODE_CODE)
         items_sent++;
   endtask

   task automatic send_scan(input logic [BYTE_W-1:0] ch);
      send_item(MODE_SCAN, ch, 6'($urandom), 6'($urandom), 16'($urandom));
   endtask

   task automatic build_dfa();
      int                n_states;
      int                n_cols;
      int                cols [$];
      logic [BYTE_W-1:0] b;
      n_states = $urandom_range(2, 6);
      n_cols   = $urandom_range(1, 5);
      dfa_states.delete();
      dfa_bytes.delete();
      dfa_states.push_back(0);
      while (dfa_states.size() < n_states)
         dfa_states.push_back($urandom_range(1, MAX_STATES - 1));
      repeat (n_cols)
         cols.push_back(($urandom_range(9) == 0) ? MAX_SYMBOLS - 1
                                                 : $urandom_range(MAX_SYMBOLS - 1));
      foreach (dfa_states[i])
         send_item(MODE_CODE, 8'($urandom), 6'(dfa_states[i]), 6'($urandom), 16'($urandom));
      foreach (cols[j]) begin
         repeat (2) begin
            b = word_byte();
            send_item(MODE_SYM, b, 6'($urandom), 6'($urandom),
                      {9'($urandom), 7'(cols[j] + 1)});
            dfa_bytes.push_back(b);
         end
      end
      // a byte that stays unmapped: absent, or a column past the last symbol
      if ($urandom_range(2) == 0)
         send_item(MODE_SYM, word_byte(), 6'($urandom), 6'($urandom),
                   {9'($urandom), ($urandom_range(1) ? 7'd0 :
                    7'($urandom_range(MAX_SYMBOLS + 1, (1 << SYM_W) - 1)))});
      foreach (dfa_states[i])
         foreach (cols[j])
            send_item(MODE_TRANS, 8'($urandom), 6'(dfa_states[i]), 6'(cols[j]),
                      next_state_value());
   endtask

   task automatic send_text();
      int                len;
      int                pick;
      logic [BYTE_W-1:0] ch;
      len = $urandom_range(1, 30);
      repeat (len) begin
         pick = $urandom_range(99);
         if (pick < 6) begin
            case ($urandom_range(2))
               0: send_item(MODE_SYM, 8'($urandom), 6'($urandom), 6'($urandom), 16'($urandom));
               1: send_item(MODE_TRANS, 8'($urandom), 6'($urandom), 6'($urandom),
                            next_state_value());
               default: send_item(MODE_CODE, 8'($urandom), 6'($urandom), 6'($urandom),
                                  16'($urandom));
            endcase
         end else if (pick < 9) begin
            send_item(3'($urandom_range(MODE_UNUSED_FIRST, MODE_UNUSED_LAST)), 8'($urandom),
                      6'($urandom), 6'($urandom), 16'($urandom));
         end else begin
            if (pick < 75)
               ch = dfa_bytes[$urandom_range(dfa_bytes.size() - 1)];
            else if (pick < 96)
               ch = $urandom_range(1) ? CHR_SPACE : 8'($urandom_range(CHR_TAB, CHR_CR));
            else
               ch = 8'($urandom);
            if (!scan_is_safe(ch))
               ch = CHR_SPACE;
            send_scan(ch);
         end
      end
      if ($urandom_range(9) != 0)
         send_item(MODE_END, 8'($urandom), 6'($urandom), 6'($urandom), 16'($urandom));
   endtask

   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            hold_req = 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL table_driven_dfa_tokenizer_top");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int texts_left;
      bit hold_done;
      texts_left            = 0;
      hold_done             = 1'b0;
      req_chan.valid        = 1'b0;
      req_chan.mode         = MODE_SCAN;
      req_chan.char_byte    = '0;
      req_chan.row_index    = '0;
      req_chan.column_index = '0;
      req_chan.entry_value  = '0;
      foreach (shadow_column[i]) shadow_column[i] = '0;
      foreach (shadow_next[i, j]) shadow_next[i][j] = UNWRITTEN;
      foreach (shadow_has_code[i]) shadow_has_code[i] = 1'b0;
      shadow_state    = 0;
      shadow_in_token = 1'b0;
      shadow_error    = 1'b0;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // table limits and the kept low bits of a symbol map entry
      send_item(MODE_CODE, 8'h00, 6'd0, 6'd0, -16'sd32768);
      send_item(MODE_CODE, 8'hFF, 6'd63, 6'd63, 16'sd32767);
      send_item(MODE_SYM, CHR_A, 6'd0, 6'd0, 16'shFF81);
      send_item(MODE_SYM, 8'hFF, 6'd0, 6'd0, 16'sd64);
      send_item(MODE_SYM, 8'h00, 6'd0, 6'd0, 16'sd65);
      send_item(MODE_TRANS, 8'h00, 6'd0, 6'd0, 16'sd63);
      send_item(MODE_TRANS, 8'h00, 6'd63, 6'd63, 16'sd0);
      send_item(MODE_TRANS, 8'h00, 6'd63, 6'd0, NONE_VALUE);
      send_item(MODE_TRANS, 8'h00, 6'd0, 6'd63, 16'sd64);
      send_item(MODE_TRANS, 8'h00, 6'd63, 6'd1, 16'sd32767);
      send_item(MODE_TRANS, 8'h00, 6'd0, 6'd1, -16'sd32768);
      // blank outside a token, a token through state 63, a load mid-text
      send_scan(CHR_SPACE);
      send_scan(CHR_A);
      send_scan(8'hFF);
      send_item(MODE_CODE, 8'h00, 6'd0, 6'd0, 16'sh1234);
      send_scan(CHR_TAB);
      send_scan(CHR_A);
      send_item(MODE_UNUSED_FIRST, 8'h00, 6'd0, 6'd0, 16'sd0);
      send_item(MODE_END, 8'h00, 6'd0, 6'd0, 16'sd0);
      send_item(MODE_END, 8'h00, 6'd0, 6'd0, 16'sd0);
      // missing transition, bytes after the error, end of text after it
      send_scan(8'hFF);
      send_scan(CHR_A);
      send_item(MODE_END, 8'h00, 6'd0, 6'd0, 16'sd0);
      send_scan(8'h00);
      send_item(MODE_UNUSED_LAST, 8'hFF, 6'd63, 6'd63, -16'sd1);
      send_item(MODE_END, 8'hFF, 6'd63, 6'd63, -16'sd1);
      send_scan(CHR_B);
      send_item(MODE_END, 8'h00, 6'd0, 6'd0, 16'sd0);

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
            default: begin send_idle_pct = 9; recv_stall_pct = 9; end
         endcase
         while (items_sent < ITEM_TARGET * (phase + 1) / PHASES) begin
            if (texts_left == 0) begin
               build_dfa();
               texts_left = $urandom_range(3, 8);
            end
            if (!hold_done && items_sent >= HOLD_AT) begin
               hold_req  = 1'b1;
               hold_done = 1'b1;
            end
            send_text();
            texts_left--;
         end
      end

      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (results_pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatches == 0)
         $display("PASS table_driven_dfa_tokenizer_top");
      else
         $display("FAIL table_driven_dfa_tokenizer_top");
      $finish;
   end

endmodule

### files.f
rtl/tdt_pkg.sv
rtl/tdt_req_if.sv
rtl/tdt_rsp_if.sv
rtl/tdt_front.sv
rtl/table_driven_dfa_tokenizer_top.sv
verif/tdt_lex_checker.sv
verif/tb_top.sv
